/* sv/lmod30_pkg.sv */
// ----------------------------------------------------------------------------
// lmod30_pkg
// Shared types and constants for the Luhn mod-30 check character block.
// ----------------------------------------------------------------------------
package lmod30_pkg;

    localparam int ALPHA_SIZE = 30;
    localparam int SYM_W      = 8;
    localparam int IDX_W      = 5;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [IDX_W-1:0] idx_t;

    // Alphabet by index; the comma appears twice, lookups take the first hit.
    localparam sym_t ALPHABET [ALPHA_SIZE] = '{
        8'h20, 8'h2C, 8'h2C, 8'h3F,
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
        8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72,
        8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A
    };

    // func codes
    localparam logic FUNC_GENERATE = 1'b0;
    localparam logic FUNC_VALIDATE = 1'b1;

    typedef struct packed {
        idx_t running_sum;
        logic double_next;
        logic mid_word;
        logic word_mode;
        logic error_seen;
    } state_t;

    typedef struct packed {
        logic bad_symbol;
        logic word_valid;
        sym_t check_symbol;
    } result_t;

endpackage

/* sv/lmod30_symbol_map.sv */
// ----------------------------------------------------------------------------
// lmod30_symbol_map
// Maps a character byte to its first index in the alphabet.
// ----------------------------------------------------------------------------
module lmod30_symbol_map (
    input  lmod30_pkg::sym_t symbol,
    output lmod30_pkg::idx_t idx,
    output logic             found
);

    // Scan from the top so the lowest matching index wins.
    always_comb begin
        idx   = '0;
        found = 1'b0;
        for (int k = lmod30_pkg::ALPHA_SIZE - 1; k >= 0; k--) begin
            if (lmod30_pkg::ALPHABET[k] == symbol) begin
                idx   = lmod30_pkg::IDX_W'(k);
                found = 1'b1;
            end
        end
    end

endmodule

/* sv/lmod30_step.sv */
// ----------------------------------------------------------------------------
// lmod30_step
// One character step: fold, modular add, word bookkeeping and result.
// ----------------------------------------------------------------------------
module lmod30_step (
    input  lmod30_pkg::state_t  cur,
    input  logic                func,
    input  lmod30_pkg::idx_t    idx,
    input  logic                found,
    input  logic                last,
    output lmod30_pkg::state_t  nxt,
    output lmod30_pkg::result_t res
);

    localparam logic [lmod30_pkg::IDX_W:0] SIZE_W  = (lmod30_pkg::IDX_W+1)'(lmod30_pkg::ALPHA_SIZE);
    localparam logic [lmod30_pkg::IDX_W:0] SIZE_M1 = (lmod30_pkg::IDX_W+1)'(lmod30_pkg::ALPHA_SIZE - 1);

    logic                        start;
    logic                        mode;
    logic                        dbl;
    lmod30_pkg::idx_t            sum0;
    logic [lmod30_pkg::IDX_W:0]  dv;
    lmod30_pkg::idx_t            add;
    logic [lmod30_pkg::IDX_W:0]  total;
    lmod30_pkg::idx_t            sum_n;
    lmod30_pkg::idx_t            cv;

    always_comb begin
        start = !cur.mid_word;
        mode  = start ? func : cur.word_mode;
        dbl   = start ? (func == lmod30_pkg::FUNC_GENERATE) : cur.double_next;
        sum0  = start ? '0 : cur.running_sum;

        // 2v < 60: 2v/30 + 2v%30 is 2v - 29 once 2v reaches 30
        dv = {idx, 1'b0};
        if (!dbl) begin
            add = idx;
        end else if (dv >= SIZE_W) begin
            add = lmod30_pkg::IDX_W'(dv - SIZE_M1);
        end else begin
            add = lmod30_pkg::IDX_W'(dv);
        end

        total = {1'b0, sum0} + {1'b0, add};
        sum_n = (total >= SIZE_W) ? lmod30_pkg::IDX_W'(total - SIZE_W)
                                  : lmod30_pkg::IDX_W'(total);

        nxt.running_sum = sum_n;
        nxt.double_next = !dbl;
        nxt.mid_word    = !last;
        nxt.word_mode   = mode;
        nxt.error_seen  = (start ? 1'b0 : cur.error_seen) | !found;

        cv = (sum_n == '0) ? '0 : lmod30_pkg::IDX_W'(SIZE_W - {1'b0, sum_n});
        res.check_symbol = (mode == lmod30_pkg::FUNC_GENERATE)
                         ? lmod30_pkg::ALPHABET[cv] : '0;
        res.word_valid   = (mode == lmod30_pkg::FUNC_VALIDATE) && (sum_n == '0);
        res.bad_symbol   = nxt.error_seen;
    end

endmodule

/* sv/luhn_mod30_check_character.sv */
// ----------------------------------------------------------------------------
// luhn_mod30_check_character
// Path: single input register stage, then result register; the word's last
//   character waits in the input register while a stalled result is held.
// Throughput: one character per cycle except during that wait.
// Reset: synchronous active-low aresetn clears the word state and both valids.
// ----------------------------------------------------------------------------
module luhn_mod30_check_character (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tuser,   // [0] func
    input  logic        s_tlast,   // word_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] check_symbol, [8] word_valid,
                                   // [9] bad_symbol, [15:10] zero
);

    // Input register: one character waiting to be folded into the word state.
    logic                in_valid_reg;
    logic                in_func_reg;
    lmod30_pkg::sym_t    in_symbol_reg;
    logic                in_last_reg;

    // Word state, advanced once per processed character.
    lmod30_pkg::state_t  state_reg;
    lmod30_pkg::state_t  state_next;

    // Result register.
    logic                m_valid_reg;
    lmod30_pkg::result_t m_result_reg;
    lmod30_pkg::result_t m_result_next;

    lmod30_pkg::idx_t    sym_idx;
    logic                sym_found;
    logic                out_free;
    logic                proc_fire;
    logic                in_fire;

    // A non-final character needs no result slot, so it never waits on m_tready.
    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    lmod30_symbol_map u_map (
        .symbol (in_symbol_reg),
        .idx    (sym_idx),
        .found  (sym_found)
    );

    lmod30_step u_step (
        .cur    (state_reg),
        .func   (in_func_reg),
        .idx    (sym_idx),
        .found  (sym_found),
        .last   (in_last_reg),
        .nxt    (state_next),
        .res    (m_result_next)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire) begin
                state_reg <= state_next;
            end

            if (proc_fire && in_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_func_reg   <= s_tuser;
            in_symbol_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
        if (proc_fire && in_last_reg) begin
            m_result_reg <= m_result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_result_reg};

endmodule

/* sv/lmod30_checker.sv */
// ----------------------------------------------------------------------------
// lmod30_checker
// Port-level checks for the Luhn mod-30 check character block.
// ----------------------------------------------------------------------------
module lmod30_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Leaving reset: no result pending, input side open.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // Generate and validate outputs never both active; padding is zero.
    a_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && (m_tdata[7:0] != 8'h00))
                     && (m_tdata[15:10] == 6'd0))
        else $error("mixed mode result");

    // A nonzero check character is always from the alphabet.
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] != 8'h00) |->
            (m_tdata[7:0] == 8'h20) || (m_tdata[7:0] == 8'h2C)
            || (m_tdata[7:0] == 8'h3F)
            || ((m_tdata[7:0] >= 8'h61) && (m_tdata[7:0] <= 8'h7A)))
        else $error("check character outside alphabet");

endmodule

bind luhn_mod30_check_character lmod30_checker u_lmod30_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
